// File: design/buzzer_tone_sequencer_assert.svh
// Assertion macros for the buzzer tone sequencer.
// Depends on a clock aclk and an active-low reset aresetn in the including module.
`ifndef BUZZER_TONE_SEQUENCER_ASSERT_SVH
`define BUZZER_TONE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define BTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("buzzer tone sequencer: same-cycle check failed");

// next-cycle implication
`define BTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("buzzer tone sequencer: next-cycle check failed");

`endif

// File: design/bts_pkg.sv
// Shared types and constants of the buzzer tone sequencer.
// No dependencies.
package bts_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_OFF   = 2'd0;
    localparam kind_t KIND_BEEP  = 2'd1;
    localparam kind_t KIND_SWEEP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_TONE  = 2'd3;

    localparam logic [15:0] SWEEP_LOW_RST  = 16'd300;
    localparam logic [15:0] SWEEP_HIGH_RST = 16'd6200;
    localparam logic [12:0] SWEEP_STEP_RST = -13'sd150;
    localparam logic [15:0] BEEP_TONE_RST  = 16'd3200;

    localparam logic [7:0] BEEPS_ENDLESS  = 8'd255;
    localparam logic [7:0] HALF_PERIOD_RST = 8'd10;

    typedef struct packed {
        logic [15:0]        sweep_low_hz;
        logic [15:0]        sweep_high_hz;
        logic signed [12:0] sweep_step_hz;
        logic [15:0]        beep_tone_hz;
    } cfg_t;

    typedef struct packed {
        logic       cmd;
        kind_t      req_kind;
        logic [1:0] req_priority;
        logic [7:0] req_beeps;
        logic [7:0] req_half_period;
        logic       req_active;
    } item_t;

    typedef struct packed {
        logic [15:0] tone_hz;
        logic        sound_on;
        logic        took_request;
    } result_t;

endpackage

// File: design/bts_in_stage.sv
// Input register of the buzzer tone sequencer.
// Depends on bts_pkg.
module bts_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bts_pkg::item_t s_item,
    input  logic           out_free,
    output logic           fire,
    output bts_pkg::item_t item
);

    logic           in_valid_reg;
    logic           in_valid_next;
    bts_pkg::item_t item_reg;

    assign s_ready       = !in_valid_reg || out_free;
    assign fire          = in_valid_reg && out_free;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !out_free);
    assign item          = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: design/bts_cfg_regs.sv
// Configuration registers of the buzzer tone sequencer.
// Depends on bts_pkg.
module bts_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output bts_pkg::cfg_t                      cfg
);

    bts_pkg::cfg_t cfg_reg;
    bts_pkg::cfg_t cfg_next;

    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                bts_pkg::REG_SWEEP_LOW:  cfg_next.sweep_low_hz  = cfg_wdata;
                bts_pkg::REG_SWEEP_HIGH: cfg_next.sweep_high_hz = cfg_wdata;
                bts_pkg::REG_SWEEP_STEP: cfg_next.sweep_step_hz = cfg_wdata[12:0];
                bts_pkg::REG_BEEP_TONE:  cfg_next.beep_tone_hz  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sweep_low_hz  <= bts_pkg::SWEEP_LOW_RST;
            cfg_reg.sweep_high_hz <= bts_pkg::SWEEP_HIGH_RST;
            cfg_reg.sweep_step_hz <= bts_pkg::SWEEP_STEP_RST;
            cfg_reg.beep_tone_hz  <= bts_pkg::BEEP_TONE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/bts_core.sv
// Sound state and single-pass step logic of the buzzer tone sequencer.
// Depends on bts_pkg and buzzer_tone_sequencer_assert.svh.
`include "buzzer_tone_sequencer_assert.svh"

module bts_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  bts_pkg::item_t   item,
    input  bts_pkg::cfg_t    cfg,
    output bts_pkg::result_t res
);

    logic          active_reg,   active_next;
    logic [1:0]    prio_reg,     prio_next;
    bts_pkg::kind_t kind_reg,    kind_next;
    logic [15:0]   tone_reg,     tone_next;
    logic [7:0]    beeps_reg,    beeps_next;
    logic [7:0]    hp_reg,       hp_next;
    logic [7:0]    phase_reg,    phase_next;

    logic signed [17:0] sweep_sum;
    logic signed [17:0] low_ext;
    logic signed [17:0] high_ext;
    logic               sweep_wrap;
    logic               step_pos;

    assign sweep_sum  = $signed({2'b00, tone_reg})
                      + $signed({{5{cfg.sweep_step_hz[12]}}, cfg.sweep_step_hz});
    assign low_ext    = $signed({2'b00, cfg.sweep_low_hz});
    assign high_ext   = $signed({2'b00, cfg.sweep_high_hz});
    assign sweep_wrap = (sweep_sum <= low_ext) || (sweep_sum > high_ext);
    assign step_pos   = !cfg.sweep_step_hz[12] && (cfg.sweep_step_hz != 13'sd0);

    always_comb begin
        active_next      = active_reg;
        prio_next        = prio_reg;
        kind_next        = kind_reg;
        tone_next        = tone_reg;
        beeps_next       = beeps_reg;
        hp_next          = hp_reg;
        phase_next       = phase_reg;
        res.tone_hz      = 16'd0;
        res.took_request = 1'b0;
        if (item.cmd) begin
            if (!active_reg || (prio_reg <= item.req_priority)) begin
                kind_next        = item.req_kind;
                prio_next        = item.req_priority;
                beeps_next       = item.req_beeps;
                hp_next          = (item.req_half_period == 8'd0) ? 8'd1
                                                                  : item.req_half_period;
                active_next      = item.req_active;
                tone_next        = 16'd0;
                phase_next       = 8'd0;
                res.took_request = 1'b1;
            end
            if (active_next && (kind_next inside {bts_pkg::KIND_BEEP, bts_pkg::KIND_SWEEP})) begin
                res.tone_hz = tone_next;
            end
        end else if (active_reg) begin
            case (kind_reg)
                bts_pkg::KIND_BEEP: begin
                    if (beeps_reg == 8'd0) begin
                        active_next = 1'b0;
                    end else begin
                        if (phase_reg == 8'd0) begin
                            if (tone_reg == 16'd0) begin
                                tone_next = cfg.beep_tone_hz;
                            end else begin
                                tone_next = 16'd0;
                                if (beeps_reg != bts_pkg::BEEPS_ENDLESS) begin
                                    beeps_next = beeps_reg - 8'd1;
                                end
                            end
                        end
                        phase_next  = (({1'b0, phase_reg} + 9'd1) == {1'b0, hp_reg}) ? 8'd0
                                                                       : phase_reg + 8'd1;
                        res.tone_hz = tone_next;
                    end
                end
                bts_pkg::KIND_SWEEP: begin
                    if (sweep_wrap) begin
                        tone_next = step_pos ? cfg.sweep_low_hz : cfg.sweep_high_hz;
                    end else begin
                        tone_next = sweep_sum[15:0];
                    end
                    res.tone_hz = tone_next;
                end
                default: ;
            endcase
        end
        res.sound_on = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            prio_reg   <= 2'd0;
            kind_reg   <= bts_pkg::KIND_OFF;
            tone_reg   <= 16'd0;
            beeps_reg  <= 8'd0;
            hp_reg     <= bts_pkg::HALF_PERIOD_RST;
            phase_reg  <= 8'd0;
        end else if (fire) begin
            active_reg <= active_next;
            prio_reg   <= prio_next;
            kind_reg   <= kind_next;
            tone_reg   <= tone_next;
            beeps_reg  <= beeps_next;
            hp_reg     <= hp_next;
            phase_reg  <= phase_next;
        end
    end

    `BTS_ASSERT_NOW(a_phase_in_range, 1'b1, (phase_reg < hp_reg) && (hp_reg != 8'd0))
    `BTS_ASSERT_NOW(a_tick_takes_nothing, !item.cmd, !res.took_request)
    `BTS_ASSERT_NEXT(a_take_clears_phase, fire && res.took_request,
                     (phase_reg == 8'd0) && (tone_reg == 16'd0))

endmodule

// File: design/bts_out_stage.sv
// Result register of the buzzer tone sequencer.
// Depends on bts_pkg.
module bts_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  bts_pkg::result_t res,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output bts_pkg::result_t m_res
);

    logic             out_valid_reg;
    logic             out_valid_next;
    bts_pkg::result_t res_reg;

    assign out_free       = !out_valid_reg || m_ready;
    assign out_valid_next = fire || (out_valid_reg && !m_ready);
    assign m_valid        = out_valid_reg;
    assign m_res          = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

endmodule

// File: design/buzzer_tone_sequencer.sv
// Top level of the buzzer tone sequencer.
// Depends on bts_pkg, bts_in_stage, bts_cfg_regs, bts_core and bts_out_stage.
//
// Takes one tick or sound request per clock and returns one result per item; each
// item passes the input register and then the result register. The sound state
// is computed combinationally from the input register, so sustained rate is one
// item per cycle whenever m_ready stays high. Configuration writes take effect on
// the next clock and belong to idle periods.
module buzzer_tone_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [1:0]                     s_req_kind,
    input  logic [1:0]                     s_req_priority,
    input  logic [7:0]                     s_req_beeps,
    input  logic [7:0]                     s_req_half_period,
    input  logic                           s_req_active,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_tone_hz,
    output logic                           m_sound_on,
    output logic                           m_took_request
);

    bts_pkg::item_t   s_item;
    bts_pkg::item_t   item;
    bts_pkg::cfg_t    cfg;
    bts_pkg::result_t res;
    bts_pkg::result_t m_res;
    logic             fire;
    logic             out_free;

    assign s_item.cmd             = s_cmd;
    assign s_item.req_kind        = s_req_kind;
    assign s_item.req_priority    = s_req_priority;
    assign s_item.req_beeps       = s_req_beeps;
    assign s_item.req_half_period = s_req_half_period;
    assign s_item.req_active      = s_req_active;

    bts_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .out_free (out_free),
        .fire     (fire),
        .item     (item)
    );

    bts_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bts_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .res     (res)
    );

    bts_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_tone_hz      = m_res.tone_hz;
    assign m_sound_on     = m_res.sound_on;
    assign m_took_request = m_res.took_request;

endmodule

// File: tb/bts_checker.sv
// Scoreboard for the buzzer tone sequencer: watches the config port and both channels,
// predicts one result per input transfer and compares it with the block's output.
// Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [1:0]                     s_req_kind,
    input  logic [1:0]                     s_req_priority,
    input  logic [7:0]                     s_req_beeps,
    input  logic [7:0]                     s_req_half_period,
    input  logic                           s_req_active,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [15:0]                    m_tone_hz,
    input  logic                           m_sound_on,
    input  logic                           m_took_request,
    output int                             mismatches,
    output int                             in_flight
);

    bts_pkg::cfg_t    cfg;
    logic             snd_active;
    logic [1:0]       snd_prio;
    bts_pkg::kind_t   snd_kind;
    logic [16:0]      snd_tone;
    logic [7:0]       snd_beeps;
    logic [7:0]       snd_half;
    logic [7:0]       snd_phase;

    bts_pkg::item_t   offered;
    bts_pkg::result_t want;
    bts_pkg::result_t pending_outputs[$];

    assign offered = {s_cmd, s_req_kind, s_req_priority, s_req_beeps,
                      s_req_half_period, s_req_active};

    function automatic bts_pkg::result_t sound_step(bts_pkg::item_t it);
        bts_pkg::result_t r;
        int               t;
        int               step;
        r = '0;
        if (it.cmd) begin
            if (!snd_active || snd_prio <= it.req_priority) begin
                snd_kind   = it.req_kind;
                snd_prio   = it.req_priority;
                snd_beeps  = it.req_beeps;
                snd_half   = (it.req_half_period == 8'd0) ? 8'd1 : it.req_half_period;
                snd_active = it.req_active;
                snd_tone   = '0;
                snd_phase  = '0;
                r.took_request = 1'b1;
            end
            if (snd_active && (snd_kind == bts_pkg::KIND_BEEP ||
                               snd_kind == bts_pkg::KIND_SWEEP)) begin
                r.tone_hz = snd_tone[15:0];
            end
        end else if (snd_active) begin
            if (snd_kind == bts_pkg::KIND_BEEP) begin
                if (snd_beeps == 8'd0) begin
                    snd_active = 1'b0;
                end else begin
                    if (snd_phase == 8'd0) begin
                        if (snd_tone == '0) begin
                            snd_tone = {1'b0, cfg.beep_tone_hz};
                        end else begin
                            snd_tone = '0;
                            if (snd_beeps != bts_pkg::BEEPS_ENDLESS) begin
                                snd_beeps = snd_beeps - 8'd1;
                            end
                        end
                    end
                    if (snd_half == 8'd0) begin
                        snd_half = 8'd1;
                    end
                    snd_phase = 8'((int'(snd_phase) + 1) % int'(snd_half));
                    r.tone_hz = snd_tone[15:0];
                end
            end else if (snd_kind == bts_pkg::KIND_SWEEP) begin
                step = $signed(cfg.sweep_step_hz);
                t = int'(snd_tone) + step;
                if (t <= int'(cfg.sweep_low_hz) || t > int'(cfg.sweep_high_hz)) begin
                    t = (step > 0) ? int'(cfg.sweep_low_hz) : int'(cfg.sweep_high_hz);
                end
                snd_tone  = 17'(t & 32'hFFFF);
                r.tone_hz = snd_tone[15:0];
            end
        end
        r.sound_on = snd_active;
        return r;
    endfunction

    initial begin
        mismatches = 0;
        in_flight  = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.sweep_low_hz  = bts_pkg::SWEEP_LOW_RST;
            cfg.sweep_high_hz = bts_pkg::SWEEP_HIGH_RST;
            cfg.sweep_step_hz = bts_pkg::SWEEP_STEP_RST;
            cfg.beep_tone_hz  = bts_pkg::BEEP_TONE_RST;
            snd_active = 1'b0;
            snd_prio   = '0;
            snd_kind   = bts_pkg::KIND_OFF;
            snd_tone   = '0;
            snd_beeps  = '0;
            snd_half   = bts_pkg::HALF_PERIOD_RST;
            snd_phase  = '0;
            pending_outputs.delete();
            in_flight <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    bts_pkg::REG_SWEEP_LOW:  cfg.sweep_low_hz  = cfg_wdata;
                    bts_pkg::REG_SWEEP_HIGH: cfg.sweep_high_hz = cfg_wdata;
                    bts_pkg::REG_SWEEP_STEP: cfg.sweep_step_hz = cfg_wdata[12:0];
                    bts_pkg::REG_BEEP_TONE:  cfg.beep_tone_hz  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_outputs.size() == 0) begin
                    $display("%0t: unexpected result transfer tone_hz %0d sound_on %0b took %0b",
                             $time, m_tone_hz, m_sound_on, m_took_request);
                    mismatches++;
                end else begin
                    want = pending_outputs.pop_front();
                    if (m_tone_hz !== want.tone_hz) begin
                        $display("%0t: tone_hz expected %0d actual %0d",
                                 $time, want.tone_hz, m_tone_hz);
                        mismatches++;
                    end
                    if (m_sound_on !== want.sound_on) begin
                        $display("%0t: sound_on expected %0b actual %0b",
                                 $time, want.sound_on, m_sound_on);
                        mismatches++;
                    end
                    if (m_took_request !== want.took_request) begin
                        $display("%0t: took_request expected %0b actual %0b",
                                 $time, want.took_request, m_took_request);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_outputs.push_back(sound_step(offered));
            end
            in_flight <= pending_outputs.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the buzzer tone sequencer testbench: clock, reset, config phases, stimulus
// and random backpressure; checking is done by bts_checker.
// Depends on bts_pkg, bts_checker and buzzer_tone_sequencer.
`timescale 1ns / 1ps

module testbench;

    localparam bts_pkg::kind_t KIND_UNUSED  = 2'd3;
    localparam int             STALL_CYCLES = 64;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bts_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_cmd;
    logic [1:0]                     s_req_kind;
    logic [1:0]                     s_req_priority;
    logic [7:0]                     s_req_beeps;
    logic [7:0]                     s_req_half_period;
    logic                           s_req_active;
    logic                           m_valid;
    logic                           m_ready;
    logic [15:0]                    m_tone_hz;
    logic                           m_sound_on;
    logic                           m_took_request;

    int mismatches;
    int in_flight;
    int send_idle_pct;
    int recv_idle_pct;
    bit stall_req;

    buzzer_tone_sequencer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_req_kind        (s_req_kind),
        .s_req_priority    (s_req_priority),
        .s_req_beeps       (s_req_beeps),
        .s_req_half_period (s_req_half_period),
        .s_req_active      (s_req_active),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tone_hz         (m_tone_hz),
        .m_sound_on        (m_sound_on),
        .m_took_request    (m_took_request)
    );

    bts_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_req_kind        (s_req_kind),
        .s_req_priority    (s_req_priority),
        .s_req_beeps       (s_req_beeps),
        .s_req_half_period (s_req_half_period),
        .s_req_active      (s_req_active),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tone_hz         (m_tone_hz),
        .m_sound_on        (m_sound_on),
        .m_took_request    (m_took_request),
        .mismatches        (mismatches),
        .in_flight         (in_flight)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bts_pkg::item_t make_item(logic c, bts_pkg::kind_t k, logic [1:0] p,
                                                 logic [7:0] b, logic [7:0] h, logic a);
        bts_pkg::item_t it;
        it.cmd             = c;
        it.req_kind        = k;
        it.req_priority    = p;
        it.req_beeps       = b;
        it.req_half_period = h;
        it.req_active      = a;
        return it;
    endfunction

    // request fields are don't-care on a tick; randomize them anyway
    function automatic bts_pkg::item_t tick_item();
        return make_item(1'b0, 2'($urandom), 2'($urandom), 8'($urandom),
                         8'($urandom), 1'($urandom));
    endfunction

    task automatic offer(bts_pkg::item_t it);
        s_valid           <= 1'b1;
        s_cmd             <= it.cmd;
        s_req_kind        <= it.req_kind;
        s_req_priority    <= it.req_priority;
        s_req_beeps       <= it.req_beeps;
        s_req_half_period <= it.req_half_period;
        s_req_active      <= it.req_active;
        do @(posedge aclk); while (!s_ready);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
    endtask

    task automatic program_config(logic [15:0] low, logic [15:0] high,
                                  logic [15:0] step, logic [15:0] tone);
        cfg_we <= 1'b1; cfg_index <= bts_pkg::REG_SWEEP_LOW;  cfg_wdata <= low;
        @(posedge aclk);
        cfg_index <= bts_pkg::REG_SWEEP_HIGH; cfg_wdata <= high; @(posedge aclk);
        cfg_index <= bts_pkg::REG_SWEEP_STEP; cfg_wdata <= step; @(posedge aclk);
        cfg_index <= bts_pkg::REG_BEEP_TONE;  cfg_wdata <= tone; @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // each sequence: a request with random content, then a run of ticks; some noise
    task automatic play_sequences(int count);
        int             sent;
        int             r;
        bts_pkg::kind_t k;
        logic [7:0]     b;
        logic [7:0]     h;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 15) begin
                offer(make_item(1'($urandom), 2'($urandom), 2'($urandom), 8'($urandom),
                                8'($urandom), 1'($urandom)));
                sent++;
            end else begin
                r = $urandom_range(0, 99);
                k = (r < 45) ? bts_pkg::KIND_BEEP : (r < 85) ? bts_pkg::KIND_SWEEP :
                    (r < 95) ? bts_pkg::KIND_OFF : KIND_UNUSED;
                r = $urandom_range(0, 99);
                b = (r < 70) ? 8'($urandom_range(1, 4)) : (r < 80) ? 8'd0 :
                    (r < 90) ? bts_pkg::BEEPS_ENDLESS : 8'($urandom_range(0, 255));
                h = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 255));
                offer(make_item(1'b1, k, 2'($urandom_range(0, 3)), b, h,
                                $urandom_range(0, 9) != 0));
                sent++;
                repeat ($urandom_range(1, 30)) begin
                    offer(tick_item());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                stall_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        aresetn           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_cmd             = 1'b0;
        s_req_kind        = bts_pkg::KIND_OFF;
        s_req_priority    = '0;
        s_req_beeps       = '0;
        s_req_half_period = '0;
        s_req_active      = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        stall_req         = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(tick_item());
        offer(make_item(1'b1, bts_pkg::KIND_BEEP, 2'd0, 8'd2, 8'd0, 1'b1));
        repeat (5) offer(tick_item());
        offer(make_item(1'b1, bts_pkg::KIND_SWEEP, 2'd3, 8'd0, 8'd255, 1'b1));
        repeat (3) offer(tick_item());
        offer(make_item(1'b1, bts_pkg::KIND_BEEP, 2'd2, 8'd1, 8'd1, 1'b1));
        offer(make_item(1'b1, KIND_UNUSED, 2'd3, 8'hFF, 8'h80, 1'b1));
        offer(tick_item());
        offer(make_item(1'b1, bts_pkg::KIND_BEEP, 2'd3, bts_pkg::BEEPS_ENDLESS, 8'd1, 1'b1));
        repeat (4) offer(tick_item());
        offer(make_item(1'b1, bts_pkg::KIND_OFF, 2'd3, 8'h55, 8'hAA, 1'b1));
        offer(tick_item());
        offer(make_item(1'b1, bts_pkg::KIND_SWEEP, 2'd3, 8'h0F, 8'hF0, 1'b0));
        offer(tick_item());

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            if (phase < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 88;
            end else if (phase < 4) begin
                send_idle_pct = 88;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: program_config(16'd0, 16'hFFFF, 16'h0FFF, 16'hFFFF);
                1: program_config(16'hFFFF, 16'd0, 16'h1000, 16'd0);
                2: program_config(16'd1000, 16'd2000, 16'd0, 16'd1);
                3: program_config(16'($urandom_range(0, 4000)),
                                  16'($urandom_range(3000, 65535)),
                                  16'($urandom), 16'($urandom));
                4: program_config(bts_pkg::SWEEP_LOW_RST, bts_pkg::SWEEP_HIGH_RST,
                                  {3'b000, bts_pkg::SWEEP_STEP_RST},
                                  bts_pkg::BEEP_TONE_RST);
                default: program_config(16'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom));
            endcase
            if (phase == 4) begin
                // hold the result side off while items keep coming
                stall_req = 1'b1;
                repeat (30) offer(tick_item());
            end
            play_sequences(310);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && in_flight == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
